@@ sv/friction_cone_projection_assert.svh @@
// Assertion macros shared by the checker of the friction cone projection
`ifndef FRICTION_CONE_PROJECTION_ASSERT_SVH
`define FRICTION_CONE_PROJECTION_ASSERT_SVH

// Clocked assertion, off while reset is held
`define FCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also watches the reset cycles
`define FCP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/fcp_pkg.sv @@
// Shared widths, types and codes of the friction cone projection
package fcp_pkg;

    localparam int FORCE_W  = 32;
    localparam int MU_W     = 16;
    localparam int MU_FRAC  = 12;
    localparam int N_W      = 32;
    localparam int SQ_STEPS = 2;
    localparam int DV_STEPS = 1;
    localparam int Q_W      = 32;
    localparam int A_W      = 49;
    localparam int NXY_W    = 96;
    localparam int DXY_W    = 65;
    localparam int NZ_W     = A_W + MU_FRAC;
    localparam int DZ_W     = 33;

    typedef enum logic [1:0] {
        REG_INSIDE  = 2'd0,
        REG_POLAR   = 2'd1,
        REG_SURFACE = 2'd2
    } t_region;

    typedef struct packed {
        logic signed [FORCE_W-1:0] x;
        logic signed [FORCE_W-1:0] y;
        logic signed [FORCE_W-1:0] z;
        logic [MU_W-1:0]           mu;
    } t_force;

    typedef struct packed {
        t_force             f;
        logic [FORCE_W-1:0] ax;
        logic [FORCE_W-1:0] ay;
        logic [N_W-1:0]     n;
    } t_norm;

    typedef struct packed {
        t_region                   region;
        logic signed [FORCE_W-1:0] x;
        logic signed [FORCE_W-1:0] y;
        logic signed [FORCE_W-1:0] z;
    } t_side;

    typedef struct packed {
        t_side            side;
        logic             sx;
        logic             sy;
        logic [NXY_W-1:0] nx;
        logic [NXY_W-1:0] ny;
        logic [DXY_W-1:0] dxy;
        logic [NZ_W-1:0]  nz;
        logic [DZ_W-1:0]  dz;
    } t_quot_in;

endpackage

@@ sv/fcp_sqrt.sv @@
// Pipelined tangential norm: abs, squares, sum, then a bit-pair square root
module fcp_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fcp_pkg::t_force i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output fcp_pkg::t_norm o_item
);
    localparam int SQ_ST = fcp_pkg::N_W / fcp_pkg::SQ_STEPS;
    localparam int NST   = 3 + SQ_ST;
    localparam int V_W   = 2 * fcp_pkg::N_W;

    typedef struct packed {
        fcp_pkg::t_force            f;
        logic [fcp_pkg::FORCE_W-1:0] ax;
        logic [fcp_pkg::FORCE_W-1:0] ay;
        logic [V_W-1:0]             px;
        logic [V_W-1:0]             py;
        logic [V_W-1:0]             v;
        logic [fcp_pkg::N_W-1:0]    r;
        logic [fcp_pkg::N_W+2:0]    rem;
    } t_sq;

    t_sq            r_st [NST];
    t_sq            n_st [NST];
    logic [NST-1:0] r_v;
    logic [NST-1:0] vin;
    logic [NST:0]   rdy;

    assign rdy[NST] = i_ready;
    assign o_ready  = rdy[0];
    assign o_valid  = r_v[NST-1];

    always_comb begin
        o_item    = '0;
        o_item.f  = r_st[NST-1].f;
        o_item.ax = r_st[NST-1].ax;
        o_item.ay = r_st[NST-1].ay;
        o_item.n  = r_st[NST-1].r;
    end

    for (genvar k = 0; k < NST; k++) begin : g_st
        assign rdy[k] = !r_v[k] || rdy[k+1];
        if (k == 0) begin : g_abs
            assign vin[k] = i_valid;
            always_comb begin
                n_st[k]    = '0;
                n_st[k].f  = i_item;
                n_st[k].ax = i_item.x[fcp_pkg::FORCE_W-1] ?
                             (~i_item.x + 32'd1) : i_item.x;
                n_st[k].ay = i_item.y[fcp_pkg::FORCE_W-1] ?
                             (~i_item.y + 32'd1) : i_item.y;
            end
        end else if (k == 1) begin : g_sq
            assign vin[k] = r_v[k-1];
            always_comb begin
                n_st[k]    = r_st[k-1];
                n_st[k].px = r_st[k-1].ax * r_st[k-1].ax;
                n_st[k].py = r_st[k-1].ay * r_st[k-1].ay;
            end
        end else if (k == 2) begin : g_sum
            assign vin[k] = r_v[k-1];
            always_comb begin
                n_st[k]     = r_st[k-1];
                n_st[k].v   = r_st[k-1].px + r_st[k-1].py;
                n_st[k].r   = '0;
                n_st[k].rem = '0;
            end
        end else begin : g_root
            assign vin[k] = r_v[k-1];
            always_comb begin
                logic [fcp_pkg::N_W+2:0] t;
                logic [fcp_pkg::N_W+2:0] trial;
                logic [fcp_pkg::N_W-1:0] r;
                logic [fcp_pkg::N_W+2:0] rem;
                n_st[k] = r_st[k-1];
                r       = r_st[k-1].r;
                rem     = r_st[k-1].rem;
                for (int s = 0; s < fcp_pkg::SQ_STEPS; s++) begin
                    // bring down the next bit pair, most significant first
                    t     = {rem[fcp_pkg::N_W:0],
                             r_st[k-1].v[V_W-1-2*((k-3)*fcp_pkg::SQ_STEPS+s) -: 2]};
                    trial = {1'b0, r, 2'b01};
                    if (t >= trial) begin
                        rem = t - trial;
                        r   = {r[fcp_pkg::N_W-2:0], 1'b1};
                    end else begin
                        rem = t;
                        r   = {r[fcp_pkg::N_W-2:0], 1'b0};
                    end
                end
                n_st[k].r   = r;
                n_st[k].rem = rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) r_v[k] <= vin[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (rdy[k]) r_st[k] <= n_st[k];
        end
    end

endmodule

@@ sv/fcp_mul.sv @@
// Region tests and the numerator and denominator products for the divides
module fcp_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  fcp_pkg::t_norm    i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output fcp_pkg::t_quot_in o_item
);
    localparam int NST = 5;
    localparam int W   = fcp_pkg::FORCE_W;

    typedef struct packed {
        fcp_pkg::t_norm               nm;
        logic [47:0]                  mun;
        logic signed [48:0]           muz;
        logic [31:0]                  mumu;
        fcp_pkg::t_region             region;
        logic [fcp_pkg::A_W-1:0]      a;
        logic [fcp_pkg::DZ_W-1:0]     d;
        logic [64:0]                  am;
        logic [fcp_pkg::DXY_W-1:0]    dn;
        logic [64:0]                  pxl;
        logic [63:0]                  pxh;
        logic [64:0]                  pyl;
        logic [63:0]                  pyh;
        logic [fcp_pkg::NXY_W-1:0]    nx;
        logic [fcp_pkg::NXY_W-1:0]    ny;
    } t_ml;

    t_ml            r_st [NST];
    t_ml            n_st [NST];
    logic [NST-1:0] r_v;
    logic [NST-1:0] vin;
    logic [NST:0]   rdy;

    assign rdy[NST] = i_ready;
    assign o_ready  = rdy[0];
    assign o_valid  = r_v[NST-1];

    always_comb begin
        o_item             = '0;
        o_item.side.region = r_st[NST-1].region;
        o_item.side.x      = r_st[NST-1].nm.f.x;
        o_item.side.y      = r_st[NST-1].nm.f.y;
        o_item.side.z      = r_st[NST-1].nm.f.z;
        o_item.sx          = r_st[NST-1].nm.f.x[W-1];
        o_item.sy          = r_st[NST-1].nm.f.y[W-1];
        o_item.nx          = r_st[NST-1].nx;
        o_item.ny          = r_st[NST-1].ny;
        o_item.dxy         = r_st[NST-1].dn;
        o_item.nz          = {r_st[NST-1].a, {fcp_pkg::MU_FRAC{1'b0}}};
        o_item.dz          = r_st[NST-1].d;
    end

    for (genvar k = 0; k < NST; k++) begin : g_st
        assign rdy[k] = !r_v[k] || rdy[k+1];
        if (k == 0) begin : g_mu
            assign vin[k] = i_valid;
            always_comb begin
                n_st[k]      = '0;
                n_st[k].nm   = i_item;
                n_st[k].mun  = i_item.f.mu * i_item.n;
                n_st[k].muz  = $signed({1'b0, i_item.f.mu}) * i_item.f.z;
                n_st[k].mumu = i_item.f.mu * i_item.f.mu;
            end
        end else if (k == 1) begin : g_region
            assign vin[k] = r_v[k-1];
            always_comb begin
                logic signed [49:0] muz_e;
                logic signed [49:0] n_sh;
                logic signed [49:0] z_sh;
                logic signed [49:0] mun_e;
                logic signed [49:0] a_full;
                n_st[k] = r_st[k-1];
                muz_e   = 50'(r_st[k-1].muz);
                n_sh    = $signed({6'd0, r_st[k-1].nm.n, {fcp_pkg::MU_FRAC{1'b0}}});
                z_sh    = $signed({{6{r_st[k-1].nm.f.z[W-1]}}, r_st[k-1].nm.f.z,
                                   {fcp_pkg::MU_FRAC{1'b0}}});
                mun_e   = $signed({2'b00, r_st[k-1].mun});
                a_full  = mun_e + z_sh;
                if (muz_e >= n_sh) begin
                    n_st[k].region = fcp_pkg::REG_INSIDE;
                end else if (z_sh < -mun_e) begin
                    n_st[k].region = fcp_pkg::REG_POLAR;
                end else begin
                    n_st[k].region = fcp_pkg::REG_SURFACE;
                end
                n_st[k].a = a_full[fcp_pkg::A_W-1:0];
                n_st[k].d = (33'd1 << (2 * fcp_pkg::MU_FRAC)) + {1'b0, r_st[k-1].mumu};
            end
        end else if (k == 2) begin : g_scale
            assign vin[k] = r_v[k-1];
            always_comb begin
                n_st[k]    = r_st[k-1];
                n_st[k].am = r_st[k-1].a * r_st[k-1].nm.f.mu;
                n_st[k].dn = r_st[k-1].d * r_st[k-1].nm.n;
            end
        end else if (k == 3) begin : g_part
            assign vin[k] = r_v[k-1];
            // split A*mu into two partial products per component
            always_comb begin
                n_st[k]     = r_st[k-1];
                n_st[k].pxl = r_st[k-1].am[32:0] * r_st[k-1].nm.ax;
                n_st[k].pxh = r_st[k-1].am[64:33] * r_st[k-1].nm.ax;
                n_st[k].pyl = r_st[k-1].am[32:0] * r_st[k-1].nm.ay;
                n_st[k].pyh = r_st[k-1].am[64:33] * r_st[k-1].nm.ay;
            end
        end else begin : g_join
            assign vin[k] = r_v[k-1];
            always_comb begin
                n_st[k]    = r_st[k-1];
                n_st[k].nx = fcp_pkg::NXY_W'({r_st[k-1].pxh, 33'd0})
                           + fcp_pkg::NXY_W'(r_st[k-1].pxl);
                n_st[k].ny = fcp_pkg::NXY_W'({r_st[k-1].pyh, 33'd0})
                           + fcp_pkg::NXY_W'(r_st[k-1].pyl);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) r_v[k] <= vin[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (rdy[k]) r_st[k] <= n_st[k];
        end
    end

endmodule

@@ sv/fcp_div.sv @@
// Pipelined rounded divide: one quotient bit per step, overflow flagged
module fcp_div #(
    parameter int NUM_W  = fcp_pkg::NXY_W,
    parameter int DEN_W  = fcp_pkg::DXY_W,
    parameter int QW     = fcp_pkg::Q_W,
    parameter int STEPS  = fcp_pkg::DV_STEPS,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [QW-1:0]     o_q,
    output logic              o_ovf,
    output logic [SIDE_W-1:0] o_side
);
    localparam int NST   = 1 + QW / STEPS;
    localparam int HI_W  = NUM_W + 1 - QW;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    typedef struct packed {
        logic [QW-1:0]     lo;
        logic [QW-1:0]     q;
        logic [DEN_W-1:0]  den;
        logic [DEN_W-1:0]  rem;
        logic              ovf;
        logic [SIDE_W-1:0] side;
    } t_dv;

    t_dv            r_st [NST];
    t_dv            n_st [NST];
    logic [NST-1:0] r_v;
    logic [NST-1:0] vin;
    logic [NST:0]   rdy;

    assign rdy[NST] = i_ready;
    assign o_ready  = rdy[0];
    assign o_valid  = r_v[NST-1];
    assign o_q      = r_st[NST-1].q;
    assign o_ovf    = r_st[NST-1].ovf;
    assign o_side   = r_st[NST-1].side;

    for (genvar k = 0; k < NST; k++) begin : g_st
        assign rdy[k] = !r_v[k] || rdy[k+1];
        if (k == 0) begin : g_prep
            assign vin[k] = i_valid;
            always_comb begin
                logic [NUM_W:0]   np;
                logic [CMP_W-1:0] hi_c;
                // add half the divisor for round half up
                np            = {1'b0, i_num} + (NUM_W+1)'(i_den >> 1);
                hi_c          = CMP_W'(np[NUM_W:QW]);
                n_st[k]       = '0;
                n_st[k].lo    = np[QW-1:0];
                n_st[k].den   = i_den;
                n_st[k].side  = i_side;
                n_st[k].ovf   = hi_c >= CMP_W'(i_den);
                n_st[k].rem   = n_st[k].ovf ? '0 : hi_c[DEN_W-1:0];
            end
        end else begin : g_step
            assign vin[k] = r_v[k-1];
            always_comb begin
                logic [DEN_W:0]   t;
                logic [DEN_W-1:0] rem;
                logic [QW-1:0]    q;
                n_st[k] = r_st[k-1];
                rem     = r_st[k-1].rem;
                q       = r_st[k-1].q;
                for (int s = 0; s < STEPS; s++) begin
                    t = {rem, r_st[k-1].lo[QW-1-((k-1)*STEPS+s)]};
                    if (t >= {1'b0, r_st[k-1].den}) begin
                        t   = t - {1'b0, r_st[k-1].den};
                        rem = t[DEN_W-1:0];
                        q   = {q[QW-2:0], 1'b1};
                    end else begin
                        rem = t[DEN_W-1:0];
                        q   = {q[QW-2:0], 1'b0};
                    end
                end
                n_st[k].rem = rem;
                n_st[k].q   = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) r_v[k] <= vin[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (rdy[k]) r_st[k] <= n_st[k];
        end
    end

endmodule

@@ sv/friction_cone_projection.sv @@
// Friction cone projection of one contact force per transaction.
// Slave channel s_axis: tdata carries force x, y, z (signed Q15.16) and mu
// (unsigned Q4.12). Master channel m_axis: tdata carries the projected
// x, y, z (signed Q15.16, saturated); tuser carries the region code
// (inside, polar zero, or projected onto the surface).
// Throughput: one transaction per cycle while m_axis_tready is high, with every stage valid-tracked.
// Pipeline: the norm (abs, squares, sum, 16 square root stages of two bits),
// the region tests and products, the three parallel divides (one quotient
// bit per stage), then saturation and the output register.
// Reset (synchronous, active low) empties every stage; no result is lost
// or made up. When the receiver holds tready low, results stay put and the
// stages behind them keep filling any bubbles, so s_axis_tready drops only
// once the whole pipeline is full.
module friction_cone_projection (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,  // force_x, force_y, force_z, friction_coeff
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,  // proj_x, proj_y, proj_z
    output logic [1:0]   m_axis_tuser   // region
);
    localparam int W = fcp_pkg::FORCE_W;

    fcp_pkg::t_force   in_item;
    fcp_pkg::t_norm    nm_item;
    fcp_pkg::t_quot_in ml_item;
    fcp_pkg::t_side    dz_side;
    logic              nm_valid, nm_ready, ml_valid, ml_ready;
    logic              vx, vy, vz, rx, ry, rz, dv_valid, out_rdy;
    logic [fcp_pkg::Q_W-1:0] qx, qy, qz;
    logic              ox, oy, oz, sx, sy;

    logic              r_ov;
    logic [W-1:0]      r_px, r_py, r_pz;
    fcp_pkg::t_region  r_reg;
    logic [W-1:0]      n_px, n_py, n_pz;

    assign in_item.x  = s_axis_tdata[31:0];
    assign in_item.y  = s_axis_tdata[63:32];
    assign in_item.z  = s_axis_tdata[95:64];
    assign in_item.mu = s_axis_tdata[111:96];

    fcp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (nm_valid),
        .i_ready (nm_ready),
        .o_item  (nm_item)
    );

    fcp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (nm_valid),
        .o_ready (nm_ready),
        .i_item  (nm_item),
        .o_valid (ml_valid),
        .i_ready (ml_ready),
        .o_item  (ml_item)
    );

    // the three dividers run in lockstep
    assign ml_ready = rx & ry & rz;
    assign dv_valid = vx & vy & vz;
    assign out_rdy  = !r_ov || m_axis_tready;

    fcp_div #(
        .NUM_W (fcp_pkg::NXY_W), .DEN_W (fcp_pkg::DXY_W), .QW (fcp_pkg::Q_W),
        .STEPS (fcp_pkg::DV_STEPS), .SIDE_W (1)
    ) u_div_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (ml_valid & ml_ready), .o_ready (rx),
        .i_num (ml_item.nx), .i_den (ml_item.dxy), .i_side (ml_item.sx),
        .o_valid (vx), .i_ready (out_rdy),
        .o_q (qx), .o_ovf (ox), .o_side (sx)
    );

    fcp_div #(
        .NUM_W (fcp_pkg::NXY_W), .DEN_W (fcp_pkg::DXY_W), .QW (fcp_pkg::Q_W),
        .STEPS (fcp_pkg::DV_STEPS), .SIDE_W (1)
    ) u_div_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (ml_valid & ml_ready), .o_ready (ry),
        .i_num (ml_item.ny), .i_den (ml_item.dxy), .i_side (ml_item.sy),
        .o_valid (vy), .i_ready (out_rdy),
        .o_q (qy), .o_ovf (oy), .o_side (sy)
    );

    fcp_div #(
        .NUM_W (fcp_pkg::NZ_W), .DEN_W (fcp_pkg::DZ_W), .QW (fcp_pkg::Q_W),
        .STEPS (fcp_pkg::DV_STEPS), .SIDE_W ($bits(fcp_pkg::t_side))
    ) u_div_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (ml_valid & ml_ready), .o_ready (rz),
        .i_num (ml_item.nz), .i_den (ml_item.dz), .i_side (ml_item.side),
        .o_valid (vz), .i_ready (out_rdy),
        .o_q (qz), .o_ovf (oz), .o_side (dz_side)
    );

    always_comb begin
        case (dz_side.region)
            fcp_pkg::REG_INSIDE: begin
                n_px = dz_side.x;
                n_py = dz_side.y;
                n_pz = dz_side.z;
            end
            fcp_pkg::REG_SURFACE: begin
                // clamp magnitudes at or past 2^31
                if (sx) n_px = (ox || qx[W-1]) ? {1'b1, {(W-1){1'b0}}} : (~qx + 32'd1);
                else    n_px = (ox || qx[W-1]) ? {1'b0, {(W-1){1'b1}}} : qx;
                if (sy) n_py = (oy || qy[W-1]) ? {1'b1, {(W-1){1'b0}}} : (~qy + 32'd1);
                else    n_py = (oy || qy[W-1]) ? {1'b0, {(W-1){1'b1}}} : qy;
                n_pz = (oz || qz[W-1]) ? {1'b0, {(W-1){1'b1}}} : qz;
            end
            default: begin
                n_px = '0;
                n_py = '0;
                n_pz = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_rdy) begin
            r_ov <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_px  <= n_px;
            r_py  <= n_py;
            r_pz  <= n_pz;
            r_reg <= dz_side.region;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_pz, r_py, r_px};
    assign m_axis_tuser  = r_reg;

endmodule

@@ sv/fcp_checker.sv @@
// Port-level checker for the friction cone projection, bound to the top level
`include "friction_cone_projection_assert.svh"

module fcp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [111:0] s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [95:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    // hold a stalled transaction
    `FCP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `FCP_ASSERT(a_polar_zero, m_axis_tvalid && m_axis_tuser == fcp_pkg::REG_POLAR |-> m_axis_tdata == 96'd0, "polar result not zero")
    `FCP_ASSERT(a_surface_z, m_axis_tvalid && m_axis_tuser == fcp_pkg::REG_SURFACE |-> !m_axis_tdata[95], "surface normal force negative")
    `FCP_ASSERT_RST(a_reset_empty, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind friction_cone_projection fcp_checker u_fcp_checker (.*);
